// ===== sv/assert_macros.svh =====
// assertion macros shared by the top, matrix and gamma modules
// no dependencies; the default form expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with explicit clock and active-low reset
`define OCC_ASSERT_CLK(label, clock, rstn, prop, msg) \
  label: assert property (@(posedge clock) disable iff (!rstn) (prop)) else $error(msg);

// default form on clk and rst_n
`define OCC_ASSERT(label, prop, msg) \
  `OCC_ASSERT_CLK(label, clk, rst_n, prop, msg)

`endif

// ===== sv/occ_pkg.sv =====
// shared types, constants and elaboration-time table builders
// for the oklch to srgb converter; no dependencies
`timescale 1ns / 1ps

package occ_pkg;

  localparam int FRAC_BITS       = 15;
  localparam int MAX_ROT         = 24;
  localparam int SINCOS_STEPS_DEF = 16;
  localparam int GAMMA_DEPTH_DEF = 1024;
  localparam int LIN_LIMIT       = 52525;
  localparam int LIN_MAX         = 3 << 23;

  typedef struct packed {
    logic [15:0] lightness;
    logic [14:0] chroma;
    logic [15:0] hue;
  } in_payload_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } out_payload_t;

  // decimal coefficient times 1e10 to q30, rounded
  function automatic longint cq(input longint unsigned n);
    return longint'((n * 64'd1048576 + 64'd4882812) / 64'd9765625);
  endfunction

  // round half up then arithmetic shift
  function automatic logic signed [63:0] rshift_round(input logic signed [63:0] v,
                                                      input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  // atan(2^-i) with 2^32 per turn
  localparam logic signed [31:0] ROT_ANGLE [MAX_ROT] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331, 32'sd21354465, 32'sd10679838, 32'sd5340245,
    32'sd2670163, 32'sd1335087, 32'sd667544, 32'sd333772,
    32'sd166886, 32'sd83443, 32'sd41722, 32'sd20861,
    32'sd10430, 32'sd5215, 32'sd2608, 32'sd1304,
    32'sd652, 32'sd326, 32'sd163, 32'sd81
  };

  localparam logic signed [33:0] LAB_TO_LMS [3][2] = '{
    '{34'(cq(64'd3963377774)), 34'(cq(64'd2158037573))},
    '{34'(-cq(64'd1055613458)), 34'(-cq(64'd638541728))},
    '{34'(-cq(64'd894841775)), 34'(-cq(64'd12914855480))}
  };

  localparam logic signed [33:0] LMS_TO_RGB [3][3] = '{
    '{34'(cq(64'd40767416621)), 34'(-cq(64'd33077115913)), 34'(cq(64'd2309699292))},
    '{34'(-cq(64'd12684380046)), 34'(cq(64'd26097574011)), 34'(-cq(64'd3413193965))},
    '{34'(-cq(64'd41960863)), 34'(-cq(64'd7034186147)), 34'(cq(64'd17076147010))}
  };

  // shift-subtract divide, elaboration only
  function automatic longint unsigned div_u64(input longint unsigned n,
                                              input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      r = (r << 1) | ((n >> b) & 64'd1);
      if (r >= d) begin
        r = r - d;
        q = q | (64'd1 << b);
      end
    end
    return q;
  endfunction

  function automatic longint unsigned sqrt_floor(input longint unsigned v_in);
    longint unsigned v;
    longint unsigned r;
    longint unsigned bit_w;
    v = v_in;
    r = 0;
    bit_w = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bit_w > v) bit_w = bit_w >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bit_w != 0) begin
        if (v >= r + bit_w) begin
          v = v - (r + bit_w);
          r = (r >> 1) + bit_w;
        end else begin
          r = r >> 1;
        end
        bit_w = bit_w >> 2;
      end
    end
    return r;
  endfunction

  // largest q30 c whose truncated cube does not exceed x
  function automatic longint unsigned cbrt_q30(input longint unsigned x);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned cube;
    lo = 0;
    hi = (64'd1 << 31) - 1;
    for (int it = 0; it < 32; it++) begin
      if (lo < hi) begin
        mid  = lo + ((hi - lo + 1) >> 1);
        cube = (((mid * mid) >> 30) * mid) >> 30;
        if (cube <= x) lo = mid;
        else hi = mid - 1;
      end
    end
    return lo;
  endfunction

  // cordic gain in q30 for a given number of steps
  function automatic longint unsigned cordic_gain(input int n);
    longint unsigned k;
    longint unsigned one;
    longint unsigned s;
    longint unsigned inv;
    k   = 64'd1 << 30;
    one = 64'd1 << 30;
    for (int i = 0; i < MAX_ROT; i++) begin
      if (i < n) begin
        s   = sqrt_floor((one + (one >> (2 * i))) << 30);
        inv = div_u64((64'd1 << 60) + (s >> 1), s);
        k   = (k * inv + (64'd1 << 29)) >> 30;
      end
    end
    return k;
  endfunction

  // encoded value at gamma node i, q30, floored at zero
  function automatic logic [31:0] gamma_node(input int i, input int depth);
    longint unsigned xq;
    longint unsigned c;
    longint unsigned q;
    longint r;
    longint v;
    xq = div_u64(((longint'(i) * 3) << 29) + longint'(depth >> 1), longint'(depth));
    c  = cbrt_q30(xq);
    q  = sqrt_floor(sqrt_floor(c << 30) << 30);
    r  = longint'((c * q) >> 30);
    v  = rshift_round(cq(64'd10550000000) * r, 30) - cq(64'd550000000);
    return (v < 0) ? 32'd0 : 32'(v);
  endfunction

endpackage

// ===== sv/oklch_to_srgb_converter_top.sv =====
// top level of the oklch to srgb converter
// depends on occ_pkg, occ_cordic, occ_matrix, occ_gamma, assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Converts one OKLCH pixel per clock to gamma-encoded sRGB in Q1.15.
// A transaction is taken at every edge where start is high; busy is always
// low. The result appears on out_data for one cycle with out_strobe high,
// once the transaction has passed the CORDIC chain (an input register, one
// stage per micro-rotation and two gain stages), eight matrix/cube stages
// and eight encode stages.
// Results cannot be held off, so the sink must take each one as it shows.
// The encode table of GAMMA_TABLE_DEPTH+1 nodes is a constant ROM read at
// two addresses per channel; no clearing pass is needed after reset.
module oklch_to_srgb_converter_top import occ_pkg::*; #(
  parameter int SINCOS_STEPS      = SINCOS_STEPS_DEF,
  parameter int GAMMA_TABLE_DEPTH = GAMMA_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  in_payload_t  in_data,
  output logic         out_strobe,
  output out_payload_t out_data
);

  localparam int LAT = SINCOS_STEPS + 19;

  logic               c_valid;
  logic [15:0]        c_lin;
  logic signed [31:0] c_a;
  logic signed [31:0] c_b;
  logic               m_valid;
  logic [24:0]        m_lin [3];
  logic [15:0]        code  [3];
  logic               g_strobe;
  logic               b_strobe;

  assign busy = 1'b0;

  // hue rotation
  occ_cordic #(.STEPS(SINCOS_STEPS)) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start),
    .in_data   (in_data),
    .out_valid (c_valid),
    .out_lin   (c_lin),
    .out_a     (c_a),
    .out_b     (c_b)
  );

  // color matrices
  occ_matrix u_matrix (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (c_valid),
    .in_lin    (c_lin),
    .in_a      (c_a),
    .in_b      (c_b),
    .out_valid (m_valid),
    .out_lin   (m_lin)
  );

  // per-channel encode, red drives the strobe
  occ_gamma #(.DEPTH(GAMMA_TABLE_DEPTH)) u_gamma_r (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (m_valid),
    .in_x      (m_lin[0]),
    .out_valid (out_strobe),
    .out_code  (code[0])
  );

  occ_gamma #(.DEPTH(GAMMA_TABLE_DEPTH)) u_gamma_g (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (m_valid),
    .in_x      (m_lin[1]),
    .out_valid (g_strobe),
    .out_code  (code[1])
  );

  occ_gamma #(.DEPTH(GAMMA_TABLE_DEPTH)) u_gamma_b (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (m_valid),
    .in_x      (m_lin[2]),
    .out_valid (b_strobe),
    .out_code  (code[2])
  );

  assign out_data.red   = code[0];
  assign out_data.green = code[1];
  assign out_data.blue  = code[2];

  `OCC_ASSERT(a_top_lat, out_strobe |-> $past(start && !busy, LAT), "result without transaction")
  `OCC_ASSERT(a_top_mid, m_valid |-> $past(c_valid, 8), "matrix valid out of step")
  `OCC_ASSERT(a_top_sat, out_strobe |-> (out_data.red <= 16'hFFFF), "red code overflow")
  `OCC_ASSERT(a_top_align, (g_strobe == out_strobe) && (b_strobe == out_strobe), "channel skew")

endmodule

// ===== sv/occ_cordic.sv =====
// hue rotation: saturation, half-turn prerotation, cordic steps and gain
// depends on occ_pkg
`timescale 1ns / 1ps

module occ_cordic import occ_pkg::*; #(
  parameter int STEPS = SINCOS_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  in_payload_t        in_data,
  output logic               out_valid,
  output logic [15:0]        out_lin,
  output logic signed [31:0] out_a,
  output logic signed [31:0] out_b
);

  localparam logic [29:0] GAIN = 30'(cordic_gain(STEPS));

  logic               v_r   [STEPS+1];
  logic signed [33:0] x_r   [STEPS+1];
  logic signed [33:0] y_r   [STEPS+1];
  logic signed [31:0] z_r   [STEPS+1];
  logic [15:0]        lin_r [STEPS+1];

  logic               left;
  logic [31:0]        u_rot;
  logic [29:0]        c_q30;
  logic [15:0]        lin_sat;

  // front end: lightness saturation, chroma always below one by width
  always_comb begin
    lin_sat = (in_data.lightness > 16'd32768) ? 16'd32768 : in_data.lightness;
    c_q30   = {in_data.chroma, 15'd0};
    left    = in_data.hue[15] ^ in_data.hue[14];
    u_rot   = {in_data.hue, 16'd0} ^ (left ? 32'h8000_0000 : 32'h0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    x_r[0]   <= left ? -$signed(34'(c_q30)) : $signed(34'(c_q30));
    y_r[0]   <= '0;
    z_r[0]   <= $signed(u_rot);
    lin_r[0] <= lin_sat;
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (!z_r[i][31]) begin
        x_r[i+1] <= x_r[i] - dx;
        y_r[i+1] <= y_r[i] + dy;
        z_r[i+1] <= z_r[i] - ROT_ANGLE[i];
      end else begin
        x_r[i+1] <= x_r[i] + dx;
        y_r[i+1] <= y_r[i] - dy;
        z_r[i+1] <= z_r[i] + ROT_ANGLE[i];
      end
      lin_r[i+1] <= lin_r[i];
    end
  end

  // gain correction: multiply, then round to q30
  logic               vg_r;
  logic               vo_r;
  logic signed [63:0] px_r;
  logic signed [63:0] py_r;
  logic [15:0]        lin_g_r;
  logic [15:0]        lin_o_r;
  logic signed [31:0] a_r;
  logic signed [31:0] b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vg_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      vg_r <= v_r[STEPS];
      vo_r <= vg_r;
    end
  end

  always_ff @(posedge clk) begin
    px_r    <= 64'(x_r[STEPS]) * 64'($signed({1'b0, GAIN}));
    py_r    <= 64'(y_r[STEPS]) * 64'($signed({1'b0, GAIN}));
    lin_g_r <= lin_r[STEPS];
    a_r     <= 32'(rshift_round(px_r, 30));
    b_r     <= 32'(rshift_round(py_r, 30));
    lin_o_r <= lin_g_r;
  end

  assign out_valid = vo_r;
  assign out_lin   = lin_o_r;
  assign out_a     = a_r;
  assign out_b     = b_r;

endmodule

// ===== sv/occ_matrix.sv =====
// oklab to lms matrix, cube, lms to linear srgb matrix and clamp
// depends on occ_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module occ_matrix import occ_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [15:0]        in_lin,
  input  logic signed [31:0] in_a,
  input  logic signed [31:0] in_b,
  output logic               out_valid,
  output logic [24:0]        out_lin [3]
);

  localparam int NST = 8;

  logic v_r [NST];

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NST; s++) v_r[s] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
      for (int s = 1; s < NST; s++) v_r[s] <= v_r[s-1];
    end
  end

  logic signed [63:0] pa_r   [3];
  logic signed [63:0] pb_r   [3];
  logic [15:0]        lin_r;
  logic signed [31:0] p_r    [3];
  logic signed [63:0] pp_r   [3];
  logic signed [31:0] p1_r   [3];
  logic signed [31:0] sq_r   [3];
  logic signed [31:0] p2_r   [3];
  logic signed [63:0] sp_r   [3];
  logic signed [31:0] cube_r [3];
  logic signed [63:0] rp_r   [3][3];
  logic [24:0]        lo_r   [3];

  logic signed [63:0] lms_sum [3];
  logic signed [63:0] rgb_sum [3];
  logic signed [63:0] rgb_v   [3];

  // lms sums and rgb rounding
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lms_sum[k] = $signed(64'(lin_r) << 45) + pa_r[k] + pb_r[k];
      rgb_sum[k] = rp_r[k][0] + rp_r[k][1] + rp_r[k][2];
      rgb_v[k]   = rshift_round(rgb_sum[k], 30);
    end
  end

  always_ff @(posedge clk) begin
    lin_r <= in_lin;
    for (int k = 0; k < 3; k++) begin
      // lab to lms products
      pa_r[k]   <= 64'(LAB_TO_LMS[k][0]) * 64'(in_a);
      pb_r[k]   <= 64'(LAB_TO_LMS[k][1]) * 64'(in_b);
      p_r[k]    <= 32'(rshift_round(lms_sum[k], 32));
      // cube in two multiplies
      pp_r[k]   <= 64'(p_r[k]) * 64'(p_r[k]);
      p1_r[k]   <= p_r[k];
      sq_r[k]   <= 32'(rshift_round(pp_r[k], 28));
      p2_r[k]   <= p1_r[k];
      sp_r[k]   <= 64'(sq_r[k]) * 64'(p2_r[k]);
      cube_r[k] <= 32'(rshift_round(sp_r[k], 32));
      // lms to rgb products
      for (int j = 0; j < 3; j++) begin
        rp_r[k][j] <= 64'(LMS_TO_RGB[k][j]) * 64'(cube_r[j]);
      end
      // clamp to 0..1.5
      if (rgb_v[k] < 0) begin
        lo_r[k] <= '0;
      end else if (rgb_v[k] > 64'(LIN_MAX)) begin
        lo_r[k] <= 25'(LIN_MAX);
      end else begin
        lo_r[k] <= 25'(rgb_v[k]);
      end
    end
  end

  assign out_valid = v_r[NST-1];
  assign out_lin   = lo_r;

  `OCC_ASSERT(a_mat_clamp, v_r[NST-2] |=> (out_lin[0] <= 25'(LIN_MAX) && out_lin[1] <= 25'(LIN_MAX) && out_lin[2] <= 25'(LIN_MAX)), "linear channel above clamp")

endmodule

// ===== sv/occ_gamma.sv =====
// srgb encode of one linear channel: linear segment or table interpolation
// depends on occ_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module occ_gamma import occ_pkg::*; #(
  parameter int DEPTH = GAMMA_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [24:0] in_x,
  output logic        out_valid,
  output logic [15:0] out_code
);

  localparam int AW  = $clog2(DEPTH + 1);
  localparam int DW  = $clog2(DEPTH + 1) + 1;
  localparam int NST = 8;

  typedef logic [31:0] rom_t [DEPTH+1];

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i <= DEPTH; i++) r[i] = gamma_node(i, DEPTH);
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  logic v_r [NST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NST; s++) v_r[s] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
      for (int s = 1; s < NST; s++) v_r[s] <= v_r[s-1];
    end
  end

  // stage 1: linear numerator, table position
  logic [33:0] lx_r;
  logic [37:0] q_r;
  logic        seg_r [NST-1];

  // stage 2: divide by 25 and by 3 through reciprocals
  logic [32:0] lm_r;
  logic [31:0] t3_r;
  logic [14:0] t_r;
  logic [22:0] low_r;

  // stage 3: address and remainder
  logic [15:0]   lin_r [3:NST-1];
  logic [AW-1:0] addr_r;
  logic [24:0]   rh_r  [3:5];

  // stages 4..8: table read and interpolation
  logic [31:0] t0_r;
  logic [31:0] t1_r;
  logic [31:0] t0b_r;
  logic [31:0] t0c_r;
  logic [31:0] t0d_r;
  logic [30:0] d_r;
  logic [55:0] w_r;
  logic [63:0] n3_r;
  logic [15:0] code_r;

  logic [13:0]   idx_full;
  logic [1:0]    r3;
  logic [31:0]   n2;
  logic [31:0]   v_sum;
  logic [16:0]   code_full;

  always_comb begin
    idx_full  = t3_r[30:17];
    r3        = 2'(t_r - 15'(3 * idx_full));
    n2        = w_r[54:23];
    v_sum     = t0d_r + n3_r[63:33];
    code_full = 17'((v_sum + (32'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
  end

  always_ff @(posedge clk) begin
    lx_r     <= 34'(in_x) * 34'd323 + 34'd6400;
    q_r      <= 38'(in_x) * 38'(DEPTH);
    seg_r[0] <= (in_x <= 25'(LIN_LIMIT));
    for (int s = 1; s < NST-1; s++) seg_r[s] <= seg_r[s-1];

    lm_r  <= 33'(lx_r[24:9]) * 33'd83887;
    t3_r  <= 32'(q_r[37:23]) * 32'd43691;
    t_r   <= q_r[37:23];
    low_r <= q_r[22:0];

    lin_r[3] <= 16'(lm_r[32:21]);
    for (int s = 4; s < NST; s++) lin_r[s] <= lin_r[s-1];
    // last interval takes the end node
    if (idx_full >= 14'(DEPTH)) begin
      addr_r   <= AW'(DEPTH - 1);
      rh_r[3]  <= 25'(3 << 23);
    end else begin
      addr_r   <= idx_full[AW-1:0];
      rh_r[3]  <= {r3, low_r};
    end
    for (int s = 4; s <= 5; s++) rh_r[s] <= rh_r[s-1];

    t0_r  <= ROM[addr_r];
    t1_r  <= ROM[AW'(DW'(addr_r) + DW'(1))];

    d_r   <= 31'(t1_r - t0_r);
    t0b_r <= t0_r;

    w_r   <= 56'(d_r) * 56'(rh_r[5]) + 56'(3 << 22);
    t0c_r <= t0b_r;

    n3_r  <= 64'(n2) * 64'h0000_0000_AAAA_AAAB;
    t0d_r <= t0c_r;

    if (seg_r[NST-2]) begin
      code_r <= lin_r[NST-1];
    end else if (code_full > 17'h0FFFF) begin
      code_r <= 16'hFFFF;
    end else begin
      code_r <= code_full[15:0];
    end
  end

  assign out_valid = v_r[NST-1];
  assign out_code  = code_r;

  `OCC_ASSERT(a_gam_mono, v_r[2] |=> (t1_r >= t0_r), "gamma table not monotone at read")

endmodule

// ===== bench/tb_oklch_to_srgb_converter_top.sv =====
// self-checking bench for the oklch to srgb converter top level
// depends on occ_pkg (payload types) and oklch_to_srgb_converter_top
`timescale 1ns / 1ps

module tb_oklch_to_srgb_converter_top;
  import occ_pkg::*;

  localparam int STEPS = 16;
  localparam int DEPTH = 1024;
  localparam int LATENCY = STEPS + 19;
  localparam longint LIN_TOP = 64'sd3 << 23;

  logic         clk;
  logic         rst_n;
  logic         start;
  logic         busy;
  in_payload_t  in_data;
  logic         out_strobe;
  out_payload_t out_data;

  oklch_to_srgb_converter_top #(
    .SINCOS_STEPS(STEPS),
    .GAMMA_TABLE_DEPTH(DEPTH)
  ) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_strobe(out_strobe), .out_data(out_data)
  );

  // pixels waiting to be sent and colors waiting to come out
  in_payload_t  pixel_queue[$];
  out_payload_t color_queue[$];
  int sender_idle_pct;
  int mismatch_count;
  int hold_off;

  // arctangent steps, 2^32 per turn
  longint atan_step[24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };
  longint lab_mat[3][2];
  longint lms_mat[3][3];
  longint unsigned gamma_rom[DEPTH + 1];
  longint cordic_k;

  function automatic longint coef(longint unsigned n);
    return longint'((n * 64'd1048576 + 64'd4882812) / 64'd9765625);
  endfunction

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint shr_round(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned icbrt(longint unsigned x);
    longint unsigned lo, hi, mid, c3;
    lo = 0;
    hi = (64'd1 << 31) - 1;
    while (lo < hi) begin
      mid = lo + ((hi - lo + 1) >> 1);
      c3 = (((mid * mid) >> 30) * mid) >> 30;
      if (c3 <= x) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // constant tables: matrices, cordic gain, encode nodes
  task automatic build_constants();
    longint unsigned k, one, s, inv, xq, c, q;
    longint r, v;
    lab_mat = '{'{coef(64'd3963377774), coef(64'd2158037573)},
                '{-coef(64'd1055613458), -coef(64'd638541728)},
                '{-coef(64'd894841775), -coef(64'd12914855480)}};
    lms_mat = '{'{coef(64'd40767416621), -coef(64'd33077115913), coef(64'd2309699292)},
                '{-coef(64'd12684380046), coef(64'd26097574011), -coef(64'd3413193965)},
                '{-coef(64'd41960863), -coef(64'd7034186147), coef(64'd17076147010)}};
    k = 64'd1 << 30;
    one = 64'd1 << 30;
    for (int i = 0; i < STEPS; i++) begin
      s = isqrt((one + (one >> (2 * i))) << 30);
      inv = ((64'd1 << 60) + (s >> 1)) / s;
      k = (k * inv + (64'd1 << 29)) >> 30;
    end
    cordic_k = longint'(k);
    for (int i = 0; i <= DEPTH; i++) begin
      xq = ((longint'(i) * 3 << 29) + DEPTH / 2) / DEPTH;
      c = icbrt(xq);
      q = isqrt(isqrt(c << 30) << 30);
      r = longint'((c * q) >> 30);
      v = shr_round(coef(64'd10550000000) * r, 30) - coef(64'd550000000);
      gamma_rom[i] = v < 0 ? 0 : longint'(v);
    end
  endtask

  function automatic logic [15:0] gamma_encode(longint x);
    longint unsigned ux, res, span, p, idx, rem, v, den;
    ux = x;
    if (ux <= LIN_LIMIT) begin
      den = 64'd25 << 24;
      res = (((ux * 323) << FRAC_BITS) + den / 2) / den;
    end else begin
      span = 64'd3 << 24;
      p = ux * 2 * DEPTH;
      idx = p / span;
      rem = p % span;
      if (idx >= DEPTH) begin
        idx = DEPTH - 1;
        rem = span;
      end
      v = (gamma_rom[idx] * (span - rem) + gamma_rom[idx + 1] * rem + span / 2) / span;
      res = (v + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    end
    return res > 64'hFFFF ? 16'hFFFF : res[15:0];
  endfunction

  // full conversion of one pixel
  function automatic out_payload_t convert_pixel(in_payload_t px);
    longint unsigned lin, chr, u;
    longint lq, cq, x, y, z, a, b, dx, dy, p, sq, v;
    longint lmsc[3];
    logic [15:0] ch[3];
    out_payload_t res;
    lin = px.lightness;
    chr = px.chroma;
    if (lin > (1 << FRAC_BITS)) lin = 1 << FRAC_BITS;
    if (chr >= (1 << FRAC_BITS)) chr = (1 << FRAC_BITS) - 1;
    lq = longint'(lin << (30 - FRAC_BITS));
    cq = longint'(chr << (30 - FRAC_BITS));
    u = longint'(px.hue) << 16;
    x = cq;
    // left half plane: pre-rotate by half a turn
    if (u >= (64'd1 << 30) && u < (64'd3 << 30)) begin
      x = -cq;
      u = (u - (64'd1 << 31)) & 64'hFFFF_FFFF;
    end
    z = u >= (64'd1 << 31) ? longint'(u) - (64'sd1 <<< 32) : longint'(u);
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step[i];
      end else begin
        x += dx; y -= dy; z += atan_step[i];
      end
    end
    a = shr_round(x * cordic_k, 30);
    b = shr_round(y * cordic_k, 30);
    for (int j = 0; j < 3; j++) begin
      p = shr_round((lq <<< 30) + lab_mat[j][0] * a + lab_mat[j][1] * b, 32);
      sq = shr_round(p * p, 28);
      lmsc[j] = shr_round(sq * p, 32);
    end
    for (int j = 0; j < 3; j++) begin
      v = shr_round(lms_mat[j][0] * lmsc[0] + lms_mat[j][1] * lmsc[1]
                    + lms_mat[j][2] * lmsc[2], 30);
      if (v < 0) v = 0;
      if (v > LIN_TOP) v = LIN_TOP;
      ch[j] = gamma_encode(v);
    end
    res.red = ch[0];
    res.green = ch[1];
    res.blue = ch[2];
    return res;
  endfunction

  function automatic in_payload_t make_pixel(int l, int c, int h);
    in_payload_t px;
    px.lightness = 16'(l);
    px.chroma = 15'(c);
    px.hue = 16'(h);
    return px;
  endfunction

  // append one pixel to the pending queue
  task automatic add_pixel(int l, int c, int h);
    pixel_queue.insert(pixel_queue.size(), make_pixel(l, c, h));
  endtask

  // clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // driver: one pending pixel per accepted transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_data <= '0;
    end else begin
      if (start && !busy) begin
        color_queue.insert(color_queue.size(), convert_pixel(in_data));
      end
      if (start && busy) begin
        // keep offering the same pixel
      end else if (hold_off == 0 && pixel_queue.size() > 0
                   && $urandom_range(99) >= sender_idle_pct) begin
        start <= 1'b1;
        in_data <= pixel_queue.pop_front();
      end else begin
        start <= 1'b0;
        in_data <= make_pixel($urandom, $urandom, $urandom);
      end
    end
  end

  // monitor: compare each result strobe with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (color_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result %h", out_data);
      end else begin
        out_payload_t exp_color;
        exp_color = color_queue.pop_front();
        if (exp_color !== out_data) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("color mismatch: r %0d/%0d g %0d/%0d b %0d/%0d (exp/act)",
                     exp_color.red, out_data.red, exp_color.green, out_data.green,
                     exp_color.blue, out_data.blue);
        end
      end
    end
  end

  // stimulus
  initial begin
    int phase_pct[4] = '{0, 85, 0, 34};
    int ll, cc;
    rst_n = 1'b0;
    mismatch_count = 0;
    hold_off = 0;
    sender_idle_pct = 0;
    build_constants();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, saturation, axes, gray ramp
    add_pixel(0, 0, 0);
    add_pixel(32768, 0, 0);
    add_pixel(65535, 32767, 65535);
    add_pixel(32769, 0, 0);
    add_pixel(16384, 32767, 0);
    add_pixel(16384, 32767, 16384);
    add_pixel(16384, 32767, 32768);
    add_pixel(16384, 32767, 49152);
    add_pixel(16384, 32767, 16383);
    add_pixel(16384, 32767, 49151);
    add_pixel(1, 0, 0);
    add_pixel(600, 0, 0);
    add_pixel(4800, 0, 0);
    add_pixel(4900, 0, 0);
    add_pixel(22000, 0, 0);
    add_pixel(32768, 32767, 21845);
    add_pixel(65535, 0, 43690);
    add_pixel(24000, 4000, 8000);
    add_pixel(0, 32767, 1000);
    add_pixel(43690, 21845, 21845);
    wait (pixel_queue.size() == 0);

    // random phases
    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = phase_pct[ph];
      for (int n = 0; n < 480; n++) begin
        case ($urandom_range(9))
          0: ll = $urandom_range(65535);
          1: ll = $urandom_range(2000);
          default: ll = $urandom_range(32768);
        endcase
        cc = $urandom_range(9) == 0 ? $urandom_range(32767) : $urandom_range(13000);
        add_pixel(ll, cc, $urandom_range(65535));
      end
      wait (pixel_queue.size() == 0);
      if (ph == 1) begin
        // sender waits for the pipe to drain
        hold_off = 1;
        repeat (2) @(posedge clk);
        wait (color_queue.size() == 0);
        hold_off = 0;
      end
    end
    repeat (2) @(posedge clk);
    wait (color_queue.size() == 0);
    repeat (LATENCY + 5) @(posedge clk);
    if (mismatch_count == 0 && color_queue.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/occ_pkg.sv
sv/occ_cordic.sv
sv/occ_matrix.sv
sv/occ_gamma.sv
sv/oklch_to_srgb_converter_top.sv
bench/tb_oklch_to_srgb_converter_top.sv
